// File: design/abt_pkg.sv
// ----------------------------------------------------------------------------
// abt_pkg
// Shared types and constants of the adaptive brightness table.
// ----------------------------------------------------------------------------
package abt_pkg;

  localparam int TABLE_SIZE  = 16;
  localparam int IDX_W       = $clog2(TABLE_SIZE);
  localparam int LVL_W       = 8;
  localparam int PWM_W       = 7;
  localparam int SENS_W      = 10;
  localparam int ACC_W       = 14;
  localparam int CMD_W       = 3;

  localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(TABLE_SIZE - 1);
  localparam logic [LVL_W-1:0] LVL_PWM     = 8'd100;
  localparam logic [LVL_W-1:0] LVL_BOOST   = 8'd34;
  localparam logic [LVL_W-1:0] LVL_MAX     = 8'd133;
  localparam logic [LVL_W-1:0] LVL_PWM_MAX = 8'd99;
  localparam logic [LVL_W-1:0] STEP_MIN    = 8'd1;
  localparam logic [LVL_W-1:0] STEP_MAX    = 8'd4;
  localparam logic [ACC_W-1:0] SENSOR_FULL = 14'd1023;
  localparam logic [ACC_W-1:0] SENS_SCALE  = ACC_W'(TABLE_SIZE - 2);

  localparam logic REG_AUTO  = 1'b0;
  localparam logic REG_BOOST = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SENSOR = 3'd0,
    CMD_INC    = 3'd1,
    CMD_DEC    = 3'd2,
    CMD_BOFF   = 3'd3,
    CMD_WRITE  = 3'd4,
    CMD_READ   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ALU_DIV   = 3'd0,
    ALU_INC   = 3'd1,
    ALU_DEC   = 3'd2,
    ALU_DN    = 3'd3,
    ALU_UP    = 3'd4,
    ALU_MAP   = 3'd5,
    ALU_WRCAP = 3'd6
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic             boost_en;
    logic [ACC_W-1:0] a;
    logic [LVL_W-1:0] b;
  } alu_in_t;

  typedef struct packed {
    logic [ACC_W-1:0] res;
    logic             ge;
    logic             boost_set;
    logic             boost_val;
  } alu_out_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [LVL_W-1:0] data;
  } tbl_wr_t;

endpackage

// File: design/abt_table.sv
// ----------------------------------------------------------------------------
// abt_table
// Level table: one write port, one registered read port, per-entry valid
// bits so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module abt_table (
  input  logic                       clk,
  input  logic                       rst,
  input  abt_pkg::tbl_wr_t           wr,
  input  logic [abt_pkg::IDX_W-1:0]  raddr,
  output logic [abt_pkg::LVL_W-1:0]  rdata
);

  logic [abt_pkg::LVL_W-1:0]      mem [abt_pkg::TABLE_SIZE];
  logic [abt_pkg::TABLE_SIZE-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= valid[raddr] ? mem[raddr] : '0;
  end

endmodule

// File: design/abt_alu.sv
// ----------------------------------------------------------------------------
// abt_alu
// Shared arithmetic unit: divide step, step up/down, neighbor clamps,
// write cap and drive level mapping.
// ----------------------------------------------------------------------------
module abt_alu (
  input  abt_pkg::alu_in_t  in,
  output abt_pkg::alu_out_t out
);

  logic [abt_pkg::LVL_W:0]   sum;
  logic [abt_pkg::LVL_W:0]   cap;
  logic [abt_pkg::LVL_W:0]   v9;
  logic [abt_pkg::LVL_W:0]   lo9;
  logic [abt_pkg::LVL_W:0]   hi9;
  logic [abt_pkg::LVL_W:0]   t9;
  logic signed [abt_pkg::LVL_W+1:0] vs;
  logic signed [abt_pkg::LVL_W+1:0] los;
  logic signed [abt_pkg::LVL_W+1:0] his;
  logic signed [abt_pkg::LVL_W+1:0] ts;

  always_comb begin
    out = '0;
    sum = {1'b0, in.b} + (abt_pkg::LVL_W+1)'(abt_pkg::STEP_MIN);
    cap = {1'b0, in.boost_en ? abt_pkg::LVL_MAX : abt_pkg::LVL_PWM_MAX};
    v9  = {1'b0, in.a[abt_pkg::LVL_W-1:0]};
    lo9 = {1'b0, in.b} + (abt_pkg::LVL_W+1)'(abt_pkg::STEP_MIN);
    hi9 = {1'b0, in.b} + (abt_pkg::LVL_W+1)'(abt_pkg::STEP_MAX);
    t9  = '0;
    vs  = signed'({2'b00, in.a[abt_pkg::LVL_W-1:0]});
    his = signed'({2'b00, in.b}) - signed'({2'b00, abt_pkg::STEP_MIN});
    los = signed'({2'b00, in.b}) - signed'({2'b00, abt_pkg::STEP_MAX});
    ts  = '0;
    case (in.op)
      abt_pkg::ALU_DIV: begin
        out.ge  = in.a >= abt_pkg::SENSOR_FULL;
        out.res = out.ge ? in.a - abt_pkg::SENSOR_FULL : in.a;
      end
      abt_pkg::ALU_INC: begin
        out.res = abt_pkg::ACC_W'((sum > cap) ? cap : sum);
      end
      abt_pkg::ALU_DEC: begin
        out.res = abt_pkg::ACC_W'((in.b != '0) ? in.b - abt_pkg::STEP_MIN : in.b);
      end
      abt_pkg::ALU_DN: begin
        t9 = (v9 < lo9) ? lo9 : v9;
        t9 = (t9 > hi9) ? hi9 : t9;
        t9 = (t9 > {1'b0, abt_pkg::LVL_MAX}) ? {1'b0, abt_pkg::LVL_MAX} : t9;
        out.res = abt_pkg::ACC_W'(t9);
      end
      abt_pkg::ALU_UP: begin
        ts = (vs > his) ? his : vs;
        ts = (ts < los) ? los : ts;
        ts = (ts < 0) ? '0 : ts;
        out.res = abt_pkg::ACC_W'(ts[abt_pkg::LVL_W-1:0]);
      end
      abt_pkg::ALU_MAP: begin
        if (in.boost_en) begin
          out.boost_set = 1'b1;
          if (in.b >= abt_pkg::LVL_PWM) begin
            out.boost_val = 1'b1;
            out.res       = abt_pkg::ACC_W'(in.b - abt_pkg::LVL_BOOST);
          end else begin
            out.res = abt_pkg::ACC_W'(in.b);
          end
        end else begin
          out.res = abt_pkg::ACC_W'((in.b >= abt_pkg::LVL_PWM) ? abt_pkg::LVL_PWM_MAX : in.b);
        end
      end
      abt_pkg::ALU_WRCAP: begin
        out.res = abt_pkg::ACC_W'((in.b > abt_pkg::LVL_MAX) ? abt_pkg::LVL_MAX : in.b);
      end
      default: begin
        out = '0;
      end
    endcase
  end

endmodule

// File: design/adaptive_brightness_table.sv
// Takes one command word at a time and returns one result word for it; the
// block is busy from acceptance until the result is loaded into the output
// register. A sensor update in auto mode divides by repeated subtraction of
// 1023 in the shared unit, up to 14 subtractions and a final compare;
// increase and decrease in auto mode walk the other entries, entry 0 apart,
// through the single table read port, reading and then writing each entry
// in turn. The result register frees the input side while a result waits.
// Configuration writes are taken every cycle and should only be issued while
// the block is idle.
// ----------------------------------------------------------------------------
// adaptive_brightness_table
// Brightness level table indexed by ambient light, with step, reshape and
// boost mapping driven by a small sequencer around one shared unit.
// ----------------------------------------------------------------------------
module adaptive_brightness_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // sensor_value[9:0], entry_index[13:10], entry_value[21:14]
  input  logic [2:0]  s_tuser,   // cmd[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // pwm_level[6:0], boost_on[7], current_entry[11:8], read_value[19:12]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic        cfg_data
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_DIV    = 11'b000_0000_0010,
    S_RD_ACT = 11'b000_0000_0100,
    S_STEP   = 11'b000_0000_1000,
    S_DN_RD  = 11'b000_0001_0000,
    S_DN_WR  = 11'b000_0010_0000,
    S_UP_RD  = 11'b000_0100_0000,
    S_UP_WR  = 11'b000_1000_0000,
    S_MAP    = 11'b001_0000_0000,
    S_RD_ENT = 11'b010_0000_0000,
    S_OUT    = 11'b100_0000_0000
  } state_t;

  state_t                       state;
  abt_pkg::cmd_t                cmd_r;
  logic [abt_pkg::ACC_W-1:0]    acc;
  logic [abt_pkg::IDX_W-1:0]    quo;
  logic [abt_pkg::IDX_W-1:0]    active;
  logic [abt_pkg::IDX_W-1:0]    idx;
  logic [abt_pkg::LVL_W-1:0]    nb;
  logic [abt_pkg::LVL_W-1:0]    cur;
  logic [abt_pkg::PWM_W-1:0]    pwm_r;
  logic [abt_pkg::LVL_W-1:0]    rd_r;
  logic                         boost_line;
  logic                         auto_en;
  logic                         boost_en;

  abt_pkg::cmd_t                in_cmd;
  logic [abt_pkg::SENS_W-1:0]   in_sens;
  logic [abt_pkg::IDX_W-1:0]    in_idx;
  logic [abt_pkg::LVL_W-1:0]    in_val;
  logic                         accept;

  abt_pkg::tbl_wr_t             tbl_wr;
  logic [abt_pkg::IDX_W-1:0]    tbl_raddr;
  logic [abt_pkg::LVL_W-1:0]    tbl_rdata;
  abt_pkg::alu_in_t             alu_in;
  abt_pkg::alu_out_t            alu_out;
  logic [abt_pkg::LVL_W-1:0]    alu_lvl;

  assign in_cmd    = abt_pkg::cmd_t'(s_tuser);
  assign in_sens   = s_tdata[9:0];
  assign in_idx    = s_tdata[13:10];
  assign in_val    = s_tdata[21:14];
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign alu_lvl   = alu_out.res[abt_pkg::LVL_W-1:0];

  abt_table u_table (
    .clk   (clk),
    .rst   (rst),
    .wr    (tbl_wr),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  abt_alu u_alu (
    .in  (alu_in),
    .out (alu_out)
  );

  // shared unit operand select
  always_comb begin
    alu_in          = '0;
    alu_in.boost_en = boost_en;
    alu_in.op       = abt_pkg::ALU_WRCAP;
    case (state)
      S_IDLE: begin
        alu_in.op = abt_pkg::ALU_WRCAP;
        alu_in.b  = in_val;
      end
      S_DIV: begin
        alu_in.op = abt_pkg::ALU_DIV;
        alu_in.a  = acc;
      end
      S_STEP: begin
        alu_in.op = (cmd_r == abt_pkg::CMD_INC) ? abt_pkg::ALU_INC : abt_pkg::ALU_DEC;
        alu_in.b  = tbl_rdata;
      end
      S_DN_WR: begin
        alu_in.op = abt_pkg::ALU_DN;
        alu_in.a  = abt_pkg::ACC_W'(tbl_rdata);
        alu_in.b  = nb;
      end
      S_UP_WR: begin
        alu_in.op = abt_pkg::ALU_UP;
        alu_in.a  = abt_pkg::ACC_W'(tbl_rdata);
        alu_in.b  = nb;
      end
      S_MAP: begin
        alu_in.op = abt_pkg::ALU_MAP;
        alu_in.b  = (cmd_r == abt_pkg::CMD_SENSOR) ? tbl_rdata : cur;
      end
      default: begin
        alu_in.op = abt_pkg::ALU_WRCAP;
      end
    endcase
  end

  // table port select
  always_comb begin
    tbl_wr    = '0;
    tbl_raddr = active;
    case (state)
      S_IDLE: begin
        tbl_raddr   = in_idx;
        tbl_wr.en   = accept && (in_cmd == abt_pkg::CMD_WRITE);
        tbl_wr.addr = in_idx;
        tbl_wr.data = alu_lvl;
      end
      S_STEP: begin
        tbl_wr.en   = 1'b1;
        tbl_wr.addr = active;
        tbl_wr.data = alu_lvl;
      end
      S_DN_RD, S_UP_RD: begin
        tbl_raddr = idx;
      end
      S_DN_WR, S_UP_WR: begin
        tbl_wr.en   = 1'b1;
        tbl_wr.addr = idx;
        tbl_wr.data = alu_lvl;
      end
      default: begin
        tbl_raddr = active;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      active     <= '0;
      boost_line <= 1'b0;
      auto_en    <= 1'b0;
      boost_en   <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_r <= in_cmd;
            pwm_r <= '0;
            rd_r  <= '0;
            case (in_cmd)
              abt_pkg::CMD_SENSOR: begin
                if (auto_en) begin
                  acc   <= abt_pkg::ACC_W'(in_sens) * abt_pkg::SENS_SCALE;
                  quo   <= '0;
                  state <= S_DIV;
                end else begin
                  active <= '0;
                  state  <= S_RD_ACT;
                end
              end
              abt_pkg::CMD_INC, abt_pkg::CMD_DEC: begin
                state <= S_RD_ACT;
              end
              abt_pkg::CMD_BOFF: begin
                if (boost_en) begin
                  boost_line <= 1'b0;
                end
                state <= S_OUT;
              end
              abt_pkg::CMD_READ: begin
                state <= S_RD_ENT;
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_DIV: begin
          if (alu_out.ge) begin
            acc <= alu_out.res;
            quo <= quo + 1'b1;
          end else begin
            if (auto_en) begin
              active <= quo + 1'b1;
            end
            state <= S_RD_ACT;
          end
        end
        S_RD_ACT: begin
          state <= (cmd_r == abt_pkg::CMD_SENSOR) ? S_MAP : S_STEP;
        end
        S_STEP: begin
          cur <= alu_lvl;
          nb  <= alu_lvl;
          if (!auto_en) begin
            state <= S_MAP;
          end else if (active >= abt_pkg::IDX_W'(2)) begin
            idx   <= active - 1'b1;
            state <= S_DN_RD;
          end else begin
            idx   <= active + 1'b1;
            state <= S_UP_RD;
          end
        end
        S_DN_RD: begin
          state <= S_DN_WR;
        end
        S_DN_WR: begin
          if (idx != abt_pkg::IDX_W'(1)) begin
            nb    <= alu_lvl;
            idx   <= idx - 1'b1;
            state <= S_DN_RD;
          end else if (active != abt_pkg::LAST_IDX) begin
            nb    <= cur;
            idx   <= active + 1'b1;
            state <= S_UP_RD;
          end else begin
            state <= S_MAP;
          end
        end
        S_UP_RD: begin
          state <= S_UP_WR;
        end
        S_UP_WR: begin
          nb <= alu_lvl;
          if (idx == abt_pkg::LAST_IDX) begin
            state <= S_MAP;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_UP_RD;
          end
        end
        S_MAP: begin
          pwm_r <= alu_out.res[abt_pkg::PWM_W-1:0];
          if (alu_out.boost_set) begin
            boost_line <= alu_out.boost_val;
          end
          state <= S_OUT;
        end
        S_RD_ENT: begin
          rd_r  <= tbl_rdata;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'b0000, rd_r, active, boost_line, pwm_r};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          abt_pkg::REG_AUTO: begin
            auto_en <= cfg_data;
            if (!cfg_data) begin
              active <= '0;
            end
          end
          abt_pkg::REG_BOOST: begin
            boost_en <= cfg_data;
            if (!cfg_data) begin
              boost_line <= 1'b0;
            end
          end
          default: begin
            auto_en <= auto_en;
          end
        endcase
      end
    end
  end

  a_manual_entry_zero: assert property (@(posedge clk) disable iff (rst)
    !auto_en |-> (active == '0))
    else $error("active entry nonzero in manual mode");

  a_boost_needs_enable: assert property (@(posedge clk) disable iff (rst)
    boost_line |-> boost_en)
    else $error("boost line high while boost disabled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input ready right after accepting a word");

  a_pwm_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[6:0] <= abt_pkg::LVL_PWM_MAX[6:0]))
    else $error("drive level above range");

endmodule

// File: sim/abt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// abt_checker
// Watches the command, result and register channels of the brightness table,
// keeps its own copy of the table and mode bits, predicts one result word per
// accepted command word and compares each returned word field by field.
// ----------------------------------------------------------------------------
module abt_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // sensor_value[9:0], entry_index[13:10], entry_value[21:14]
  input  logic [2:0]  s_tuser,   // cmd[2:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // pwm_level[6:0], boost_on[7], current_entry[11:8], read_value[19:12]
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic        cfg_data,
  output int unsigned errors,
  output int unsigned outstanding
);

  typedef struct packed {
    logic [abt_pkg::PWM_W-1:0] pwm;
    logic                      boost;
    logic [abt_pkg::IDX_W-1:0] entry;
    logic [abt_pkg::LVL_W-1:0] rd;
  } bright_result_t;

  logic [abt_pkg::LVL_W-1:0] level_tbl [abt_pkg::TABLE_SIZE];
  logic [abt_pkg::IDX_W-1:0] act_idx;
  logic                      boost_line_q;
  logic                      auto_q;
  logic                      boost_en_q;
  bright_result_t            expected_words [$];
  int unsigned               mismatch_cnt = 0;

  assign errors = mismatch_cnt;

  // maps a table level to the drive level, updating the boost line
  task automatic drive_level(input logic [abt_pkg::LVL_W-1:0] lvl,
                             output logic [abt_pkg::PWM_W-1:0] pwm);
    if (boost_en_q) begin
      boost_line_q = (lvl >= abt_pkg::LVL_PWM);
      pwm = boost_line_q ? abt_pkg::PWM_W'(lvl - abt_pkg::LVL_BOOST)
                         : abt_pkg::PWM_W'(lvl);
    end else begin
      pwm = (lvl >= abt_pkg::LVL_PWM) ? abt_pkg::PWM_W'(abt_pkg::LVL_PWM_MAX)
                                      : abt_pkg::PWM_W'(lvl);
    end
  endtask

  // pull neighbors into a 1..4 slope away from the active entry
  task automatic smooth_table();
    int v;
    int nb;
    for (int i = int'(act_idx) - 1; i >= 1; i--) begin
      v  = int'(level_tbl[i]);
      nb = int'(level_tbl[i+1]);
      if (v < nb + int'(abt_pkg::STEP_MIN)) v = nb + int'(abt_pkg::STEP_MIN);
      if (v > nb + int'(abt_pkg::STEP_MAX)) v = nb + int'(abt_pkg::STEP_MAX);
      if (v > int'(abt_pkg::LVL_MAX)) v = int'(abt_pkg::LVL_MAX);
      level_tbl[i] = abt_pkg::LVL_W'(v);
    end
    for (int i = int'(act_idx) + 1; i < abt_pkg::TABLE_SIZE; i++) begin
      v  = int'(level_tbl[i]);
      nb = int'(level_tbl[i-1]);
      if (v > nb - int'(abt_pkg::STEP_MIN)) v = nb - int'(abt_pkg::STEP_MIN);
      if (v < nb - int'(abt_pkg::STEP_MAX)) v = nb - int'(abt_pkg::STEP_MAX);
      if (v < 0) v = 0;
      level_tbl[i] = abt_pkg::LVL_W'(v);
    end
  endtask

  task automatic predict_word(input logic [abt_pkg::CMD_W-1:0] cmd,
                              input logic [abt_pkg::SENS_W-1:0] sens,
                              input logic [abt_pkg::IDX_W-1:0] eidx,
                              input logic [abt_pkg::LVL_W-1:0] eval,
                              output bright_result_t res);
    int v;
    res = '0;
    case (cmd)
      abt_pkg::CMD_SENSOR: begin
        if (auto_q) begin
          v = int'(sens) * (abt_pkg::TABLE_SIZE - 2) / int'(abt_pkg::SENSOR_FULL) + 1;
        end else begin
          v = 0;
        end
        if (v >= abt_pkg::TABLE_SIZE) v = abt_pkg::TABLE_SIZE - 1;
        act_idx = abt_pkg::IDX_W'(v);
        drive_level(level_tbl[act_idx], res.pwm);
      end
      abt_pkg::CMD_INC: begin
        v = int'(level_tbl[act_idx]) + 1;
        if (boost_en_q) begin
          if (v > int'(abt_pkg::LVL_MAX)) v = int'(abt_pkg::LVL_MAX);
        end else if (v > int'(abt_pkg::LVL_PWM_MAX)) begin
          v = int'(abt_pkg::LVL_PWM_MAX);
        end
        level_tbl[act_idx] = abt_pkg::LVL_W'(v);
        if (auto_q) smooth_table();
        drive_level(level_tbl[act_idx], res.pwm);
      end
      abt_pkg::CMD_DEC: begin
        if (level_tbl[act_idx] != '0) level_tbl[act_idx] = level_tbl[act_idx] - 1'b1;
        if (auto_q) smooth_table();
        drive_level(level_tbl[act_idx], res.pwm);
      end
      abt_pkg::CMD_BOFF: begin
        if (boost_en_q) boost_line_q = 1'b0;
      end
      abt_pkg::CMD_WRITE: begin
        if (int'(eidx) < abt_pkg::TABLE_SIZE) begin
          level_tbl[eidx] = (eval > abt_pkg::LVL_MAX) ? abt_pkg::LVL_MAX : eval;
        end
      end
      abt_pkg::CMD_READ: begin
        if (int'(eidx) < abt_pkg::TABLE_SIZE) res.rd = level_tbl[eidx];
      end
      default: ;
    endcase
    res.boost = boost_line_q;
    res.entry = act_idx;
  endtask

  always @(posedge clk) begin
    bright_result_t got;
    bright_result_t want;
    if (rst) begin
      for (int i = 0; i < abt_pkg::TABLE_SIZE; i++) level_tbl[i] = '0;
      act_idx      = '0;
      boost_line_q = 1'b0;
      auto_q       = 1'b0;
      boost_en_q   = 1'b0;
      expected_words.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.pwm   = m_tdata[6:0];
        got.boost = m_tdata[7];
        got.entry = m_tdata[11:8];
        got.rd    = m_tdata[19:12];
        if (expected_words.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("%0t: unexpected result word pwm=%0d boost=%0d entry=%0d read=%0d",
                     $time, got.pwm, got.boost, got.entry, got.rd);
          mismatch_cnt++;
        end else begin
          want = expected_words.pop_front();
          if (got.pwm != want.pwm || got.boost != want.boost ||
              got.entry != want.entry || got.rd != want.rd) begin
            if (mismatch_cnt < 10)
              $display("%0t: result mismatch exp pwm=%0d boost=%0d entry=%0d read=%0d, %s",
                       $time, want.pwm, want.boost, want.entry, want.rd,
                       $sformatf("got pwm=%0d boost=%0d entry=%0d read=%0d",
                                 got.pwm, got.boost, got.entry, got.rd));
            mismatch_cnt++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == abt_pkg::REG_AUTO) begin
          auto_q = cfg_data;
          if (!cfg_data) act_idx = '0;
        end else begin
          boost_en_q = cfg_data;
          if (!cfg_data) boost_line_q = 1'b0;
        end
      end
      if (s_tvalid && s_tready) begin
        predict_word(s_tuser, s_tdata[9:0], s_tdata[13:10], s_tdata[21:14], want);
        expected_words.push_back(want);
      end
    end
    outstanding <= expected_words.size();
  end

endmodule

// File: sim/tb_adaptive_brightness_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_adaptive_brightness_table
// Drives command words and mode register writes into the brightness table,
// with random stalls on both sides, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_adaptive_brightness_table;

  localparam logic [abt_pkg::CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [abt_pkg::CMD_W-1:0] CMD_SPARE_B = 3'd7;
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 115;
  localparam int CALM_PHASE  = 5;
  localparam int STALL_PCT   = 28;
  localparam int TAIL_CYCLES = 60;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic        cfg_data;
  logic        calm;
  int unsigned errors;
  int unsigned outstanding;

  adaptive_brightness_table i_dut (.*);

  abt_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= calm || ($urandom_range(99) >= STALL_PCT);
    end
  end

  task automatic send_word(input logic [abt_pkg::CMD_W-1:0] cmd,
                           input logic [abt_pkg::SENS_W-1:0] sens,
                           input logic [abt_pkg::IDX_W-1:0] idx,
                           input logic [abt_pkg::LVL_W-1:0] val);
    while (!calm && $urandom_range(99) < STALL_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {2'b00, val, idx, sens};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_mode(input logic auto_en, input logic boost_en);
    write_reg(abt_pkg::REG_AUTO, auto_en);
    write_reg(abt_pkg::REG_BOOST, boost_en);
    cfg_valid <= 1'b0;
  endtask

  // wait until every command word has its result back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random();
    int unsigned pick;
    logic [abt_pkg::CMD_W-1:0]  cmd;
    logic [abt_pkg::SENS_W-1:0] sens;
    logic [abt_pkg::IDX_W-1:0]  idx;
    logic [abt_pkg::LVL_W-1:0]  val;
    pick = $urandom_range(99);
    sens = abt_pkg::SENS_W'($urandom);
    idx  = abt_pkg::IDX_W'($urandom);
    val  = abt_pkg::LVL_W'($urandom_range(int'(abt_pkg::LVL_MAX)));
    if (pick < 24) begin
      cmd = abt_pkg::CMD_SENSOR;
      case ($urandom_range(9))
        0: sens = '0;
        1: sens = '1;
        default: ;
      endcase
    end else if (pick < 44) begin
      cmd = abt_pkg::CMD_INC;
    end else if (pick < 58) begin
      cmd = abt_pkg::CMD_DEC;
    end else if (pick < 63) begin
      cmd = abt_pkg::CMD_BOFF;
    end else if (pick < 78) begin
      cmd = abt_pkg::CMD_WRITE;
      case ($urandom_range(9))
        0: val = abt_pkg::LVL_W'($urandom);
        1: val = abt_pkg::LVL_W'($urandom_range(105, 95));
        2: val = abt_pkg::LVL_W'($urandom_range(140, 128));
        default: ;
      endcase
    end else if (pick < 93) begin
      cmd = abt_pkg::CMD_READ;
    end else begin
      cmd = $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
    end
    send_word(cmd, sens, idx, val);
  endtask

  initial begin
    calm      = 1'b0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = abt_pkg::CMD_SENSOR;
    cfg_valid = 1'b0;
    cfg_index = abt_pkg::REG_AUTO;
    cfg_data  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // manual mode, no boost
    send_word(abt_pkg::CMD_READ, '0, 4'd3, '0);
    send_word(abt_pkg::CMD_WRITE, '1, 4'd0, 8'd255);
    send_word(abt_pkg::CMD_READ, '0, 4'd0, '0);
    send_word(abt_pkg::CMD_SENSOR, 10'd1023, '0, '0);
    send_word(abt_pkg::CMD_INC, '0, '0, '0);
    send_word(abt_pkg::CMD_DEC, '0, '0, '0);
    send_word(abt_pkg::CMD_BOFF, '0, '0, '0);
    send_word(CMD_SPARE_A, '1, '1, '1);
    send_word(CMD_SPARE_B, '0, '0, '0);

    // auto mode with boost
    drain();
    set_mode(1'b1, 1'b1);
    send_word(abt_pkg::CMD_WRITE, '0, 4'd15, 8'd133);
    send_word(abt_pkg::CMD_SENSOR, 10'd1023, '0, '0);
    send_word(abt_pkg::CMD_INC, '0, '0, '0);
    send_word(abt_pkg::CMD_SENSOR, 10'd0, '0, '0);
    send_word(abt_pkg::CMD_DEC, '0, '0, '0);
    send_word(abt_pkg::CMD_BOFF, '0, '0, '0);
    send_word(abt_pkg::CMD_READ, '0, 4'd15, '0);

    // manual mode with boost, floor and boost mapping
    drain();
    set_mode(1'b0, 1'b1);
    send_word(abt_pkg::CMD_WRITE, '0, 4'd0, 8'd0);
    send_word(abt_pkg::CMD_DEC, '0, '0, '0);
    send_word(abt_pkg::CMD_WRITE, '0, 4'd0, 8'd100);
    send_word(abt_pkg::CMD_SENSOR, 10'd300, '0, '0);
    send_word(abt_pkg::CMD_BOFF, '0, '0, '0);
    send_word(abt_pkg::CMD_INC, '0, '0, '0);
    send_word(abt_pkg::CMD_READ, '0, 4'd0, '0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p < 4) set_mode(1'(p % 2), 1'(p / 2));
      else set_mode(1'($urandom_range(1)), 1'($urandom_range(1)));
      calm <= (p == CALM_PHASE);
      repeat (PHASE_WORDS) send_random();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
design/abt_pkg.sv
design/abt_table.sv
design/abt_alu.sv
design/adaptive_brightness_table.sv
sim/abt_checker.sv
sim/tb_adaptive_brightness_table.sv
